// File: rtl/iirdf2_pkg.sv
`timescale 1ns / 1ps

package iirdf2_pkg;

   // fixed field widths and counts
   localparam int COEF_WIDTH  = 18;
   localparam int AUX_WIDTH   = 24;
   localparam int NUM_TAPS    = 3;
   localparam int NUM_REGS    = 7;
   localparam int PADDR_WIDTH = 5;
   localparam int PDATA_WIDTH = 32;
   localparam int REG_WIDTH   = 3;
   localparam int STEP_WIDTH  = 4;

   // register indexes, also used as coefficient selects
   localparam logic [REG_WIDTH-1:0] REG_B0 = 3'd0;
   localparam logic [REG_WIDTH-1:0] REG_B1 = 3'd1;
   localparam logic [REG_WIDTH-1:0] REG_B2 = 3'd2;
   localparam logic [REG_WIDTH-1:0] REG_B3 = 3'd3;
   localparam logic [REG_WIDTH-1:0] REG_A1 = 3'd4;
   localparam logic [REG_WIDTH-1:0] REG_A2 = 3'd5;
   localparam logic [REG_WIDTH-1:0] REG_A3 = 3'd6;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE = 18'd16384;

   // multiplier data operand
   localparam logic [1:0] DSEL_H0 = 2'd0;
   localparam logic [1:0] DSEL_H1 = 2'd1;
   localparam logic [1:0] DSEL_H2 = 2'd2;
   localparam logic [1:0] DSEL_W  = 2'd3;

   // accumulate destination
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_W    = 2'd1;
   localparam logic [1:0] ACC_Y    = 2'd2;

   // step advance condition
   localparam logic [1:0] COND_ALWAYS   = 2'd0;
   localparam logic [1:0] COND_REQ      = 2'd1;
   localparam logic [1:0] COND_OUT_FREE = 2'd2;

   typedef logic [NUM_REGS-1:0][COEF_WIDTH-1:0] coef_bank_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0]  coef_sel;
      logic [1:0]            data_sel;
      logic [1:0]            acc_sel;
      logic                  init;
      logic                  load_w;
      logic                  shift_hist;
      logic                  out_load;
      logic [1:0]            cond;
      logic [STEP_WIDTH-1:0] next_step;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
   } seq_status_type;

endpackage

// File: rtl/iir_direct_form2_filter.sv
`timescale 1ns / 1ps

// Third-order direct form II IIR filter, one signed sample per word.
// Input words arrive on req_valid / req_stall / req_sample_in; filtered
// words leave on rsp_valid / rsp_stall / rsp_sample_out. Coefficients
// (Q3.14, b0..b3 then a1..a3) are written over the APB port at byte
// offsets 0x00..0x18; write them only while the filter is idle.
// A microcoded sequencer runs each sample through one shared 18x24
// multiplier and two accumulators (w and y): a ten-step program whose
// last step loads the output register, so a new input word waits until
// the sequencer is back in its wait step.
// req_stall is high from the accept until the sequencer returns to its
// wait step. If the receiver stalls a finished word, the sequencer holds
// in its last step until the output register frees up, and the next
// input word waits behind it. Reset clears the w history, sets b0 to 1.0
// and all other coefficients to zero, and drops rsp_valid.
module iir_direct_form2_filter #(
   parameter int HISTORY_DEPTH  = 3,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [iirdf2_pkg::PADDR_WIDTH-1:0]   paddr,
   input  logic [iirdf2_pkg::PDATA_WIDTH-1:0]   pwdata,
   output logic [iirdf2_pkg::PDATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import iirdf2_pkg::*;

   coef_bank_type  coefs;
   ctl_word_type   ctl;
   seq_status_type status;
   logic           out_free;

   assign status.req_valid = req_valid;
   assign status.out_free  = out_free;

   iirdf2_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coefs   (coefs)
   );

   iirdf2_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .ctl       (ctl),
      .req_stall (req_stall)
   );

   iirdf2_dp #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .coefs          (coefs),
      .req_sample_in  (req_sample_in),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// File: rtl/iirdf2_csr.sv
`timescale 1ns / 1ps

module iirdf2_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [iirdf2_pkg::PADDR_WIDTH-1:0]   paddr,
   input  logic [iirdf2_pkg::PDATA_WIDTH-1:0]   pwdata,
   output logic [iirdf2_pkg::PDATA_WIDTH-1:0]   prdata,
   output logic                                 pready,
   output iirdf2_pkg::coef_bank_type            coefs
);
   import iirdf2_pkg::*;

   logic [COEF_WIDTH-1:0] coef_ff [NUM_REGS];
   logic [REG_WIDTH-1:0]  reg_idx;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[PADDR_WIDTH-1:2];
   assign wr_en   = psel && penable && pwrite && (reg_idx < REG_WIDTH'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            coef_ff[k] <= (k == int'(REG_B0)) ? COEF_ONE : '0;
         end
      end else if (wr_en) begin
         coef_ff[reg_idx] <= pwdata[COEF_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx < REG_WIDTH'(NUM_REGS)) begin
         prdata = PDATA_WIDTH'(signed'(coef_ff[reg_idx]));
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_REGS; k++) begin
         coefs[k] = coef_ff[k];
      end
   end

endmodule

// File: rtl/iirdf2_seq.sv
`timescale 1ns / 1ps

module iirdf2_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  iirdf2_pkg::seq_status_type  status,
   output iirdf2_pkg::ctl_word_type    ctl,
   output logic                        req_stall
);
   import iirdf2_pkg::*;

   localparam logic [STEP_WIDTH-1:0] STEP_IDLE = 4'd0;

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   ctl_word_type          word;
   logic                  cond_met;

   // microcode: one word per step, multiplies overlap the accumulate of
   // the previous product
   function automatic ctl_word_type ucode(input logic [STEP_WIDTH-1:0] step);
      ctl_word_type w;
      w = '0;
      w.cond = COND_ALWAYS;
      w.next_step = step + STEP_WIDTH'(1);
      unique case (step)
         4'd0: begin
            w.cond = COND_REQ;
            w.init = 1'b1;
         end
         4'd1: begin
            w.coef_sel = REG_A1; w.data_sel = DSEL_H0;
         end
         4'd2: begin
            w.coef_sel = REG_A2; w.data_sel = DSEL_H1; w.acc_sel = ACC_W;
         end
         4'd3: begin
            w.coef_sel = REG_A3; w.data_sel = DSEL_H2; w.acc_sel = ACC_W;
         end
         4'd4: begin
            w.coef_sel = REG_B1; w.data_sel = DSEL_H0; w.acc_sel = ACC_W;
         end
         4'd5: begin
            w.coef_sel = REG_B2; w.data_sel = DSEL_H1; w.acc_sel = ACC_Y;
            w.load_w   = 1'b1;
         end
         4'd6: begin
            w.coef_sel = REG_B0; w.data_sel = DSEL_W; w.acc_sel = ACC_Y;
         end
         4'd7: begin
            w.coef_sel = REG_B3; w.data_sel = DSEL_H2; w.acc_sel = ACC_Y;
         end
         4'd8: begin
            w.acc_sel    = ACC_Y;
            w.shift_hist = 1'b1;
         end
         4'd9: begin
            w.cond      = COND_OUT_FREE;
            w.out_load  = 1'b1;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   assign word = ucode(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_REQ:      cond_met = status.req_valid;
         COND_OUT_FREE: cond_met = status.out_free;
         default:       cond_met = 1'b1;
      endcase
   end

   // a held step issues no side effects
   always_comb begin
      ctl = word;
      if (!cond_met) begin
         ctl.init     = 1'b0;
         ctl.out_load = 1'b0;
      end
   end

   assign step_in   = cond_met ? word.next_step : step_ff;
   assign req_stall = (step_ff != STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/iirdf2_dp.sv
`timescale 1ns / 1ps

module iirdf2_dp #(
   parameter int HISTORY_DEPTH  = 3,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  iirdf2_pkg::ctl_word_type       ctl,
   input  iirdf2_pkg::coef_bank_type      coefs,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           out_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out
);
   import iirdf2_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + AUX_WIDTH;
   // rounded products stay within 28 bits; four of them plus the sample fit
   localparam int ACC_WIDTH  = 40;
   localparam logic [PROD_WIDTH:0] RND_HALF = (PROD_WIDTH + 1)'(1) << (COEF_FRAC_BITS - 1);

   logic signed [AUX_WIDTH-1:0]    hist_ff [HISTORY_DEPTH];
   logic signed [AUX_WIDTH-1:0]    hist_view [NUM_TAPS];
   logic signed [AUX_WIDTH-1:0]    w_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [PROD_WIDTH-1:0]   prod_in;
   logic signed [ACC_WIDTH-1:0]    acc_w_ff;
   logic signed [ACC_WIDTH-1:0]    acc_w_in;
   logic signed [ACC_WIDTH-1:0]    acc_y_ff;
   logic signed [ACC_WIDTH-1:0]    acc_y_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff;
   logic                           rsp_valid_ff;
   logic signed [COEF_WIDTH-1:0]   mul_coef;
   logic signed [AUX_WIDTH-1:0]    mul_data;
   logic signed [PROD_WIDTH:0]     prod_sum;
   logic signed [PROD_WIDTH:0]     prod_shift;
   logic signed [ACC_WIDTH-1:0]    rnd_term;

   function automatic logic signed [AUX_WIDTH-1:0] sat_aux(
      input logic signed [ACC_WIDTH-1:0] v
   );
      logic [ACC_WIDTH-AUX_WIDTH:0] upper;
      upper = v[ACC_WIDTH-1:AUX_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return v[AUX_WIDTH-1:0];
      end
      return {v[ACC_WIDTH-1], {(AUX_WIDTH-1){~v[ACC_WIDTH-1]}}};
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
      input logic signed [ACC_WIDTH-1:0] v
   );
      logic [ACC_WIDTH-SAMPLE_WIDTH:0] upper;
      upper = v[ACC_WIDTH-1:SAMPLE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return v[SAMPLE_WIDTH-1:0];
      end
      return {v[ACC_WIDTH-1], {(SAMPLE_WIDTH-1){~v[ACC_WIDTH-1]}}};
   endfunction

   // taps beyond the configured depth read as zero
   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_view
      if (k < HISTORY_DEPTH) begin : g_used
         assign hist_view[k] = hist_ff[k];
      end else begin : g_unused
         assign hist_view[k] = '0;
      end
   end

   always_comb begin
      mul_coef = coefs[ctl.coef_sel];
      unique case (ctl.data_sel)
         DSEL_H0: mul_data = hist_view[0];
         DSEL_H1: mul_data = hist_view[1];
         DSEL_H2: mul_data = hist_view[2];
         default: mul_data = w_ff;
      endcase
      prod_in = PROD_WIDTH'(mul_coef) * PROD_WIDTH'(mul_data);
   end

   // round half up: add half an LSB, then floor shift
   always_comb begin
      prod_sum   = {prod_ff[PROD_WIDTH-1], prod_ff} + RND_HALF;
      prod_shift = prod_sum >>> COEF_FRAC_BITS;
      rnd_term   = prod_shift[ACC_WIDTH-1:0];
   end

   always_comb begin
      acc_w_in = acc_w_ff;
      acc_y_in = acc_y_ff;
      if (ctl.init) begin
         acc_w_in = ACC_WIDTH'(req_sample_in);
         acc_y_in = '0;
      end else begin
         if (ctl.acc_sel == ACC_W) begin
            acc_w_in = acc_w_ff + rnd_term;
         end
         if (ctl.acc_sel == ACC_Y) begin
            acc_y_in = acc_y_ff + rnd_term;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_w_ff <= acc_w_in;
      acc_y_ff <= acc_y_in;
      if (ctl.load_w) begin
         w_ff <= sat_aux(acc_w_ff);
      end
      if (ctl.out_load) begin
         sample_out_ff <= sat_out(acc_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (ctl.shift_hist) begin
         hist_ff[0] <= w_ff;
         for (int k = 1; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_out_ff;

endmodule

// File: dv/iir_direct_form2_filter_checker.sv
`timescale 1ns / 1ps

module iir_direct_form2_filter_checker #(
   parameter int HISTORY_DEPTH  = 3,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [iirdf2_pkg::PADDR_WIDTH-1:0]   paddr,
   input  logic [iirdf2_pkg::PDATA_WIDTH-1:0]   pwdata,
   output int                                   mismatches,
   output int                                   words_pending,
   output int                                   words_checked,
   output int                                   aux_clamps,
   output int                                   out_clamps
);
   import iirdf2_pkg::*;

   localparam int DEPTH_USED = (HISTORY_DEPTH > NUM_TAPS) ? NUM_TAPS : HISTORY_DEPTH;

   logic signed [COEF_WIDTH-1:0]   coef_reg [NUM_REGS];
   logic signed [AUX_WIDTH-1:0]    aux_hist [NUM_TAPS];   // newest first
   logic signed [SAMPLE_WIDTH-1:0] expected_words [$];

   // product rounded half up, then back to integer scale
   function automatic longint round_mul(longint c, longint d);
      return (c * d + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   endfunction

   function automatic longint clamp(longint v, int width);
      longint hi;
      hi = (longint'(1) <<< (width - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
      logic signed [SAMPLE_WIDTH-1:0] x
   );
      longint acc;
      longint w;
      longint y;
      acc = x;
      for (int k = 0; k < DEPTH_USED; k++)
         acc += round_mul(coef_reg[REG_A1 + k], aux_hist[k]);
      w = clamp(acc, AUX_WIDTH);
      if (w != acc) aux_clamps++;
      y = round_mul(coef_reg[REG_B0], w);
      for (int k = 0; k < DEPTH_USED; k++)
         y += round_mul(coef_reg[REG_B1 + k], aux_hist[k]);
      if (clamp(y, SAMPLE_WIDTH) != y) out_clamps++;
      y = clamp(y, SAMPLE_WIDTH);
      for (int k = NUM_TAPS - 1; k > 0; k--)
         aux_hist[k] = aux_hist[k - 1];
      aux_hist[0] = AUX_WIDTH'(w);
      return SAMPLE_WIDTH'(y);
   endfunction

   always @(posedge clock) begin : monitor
      logic signed [SAMPLE_WIDTH-1:0] want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            coef_reg[i] = '0;
         coef_reg[REG_B0] = COEF_ONE;
         for (int k = 0; k < NUM_TAPS; k++)
            aux_hist[k] = '0;
         expected_words.delete();
      end else begin
         // writes past the last coefficient are dropped
         if (psel && penable && pwrite && pready && paddr[PADDR_WIDTH-1:2] < NUM_REGS)
            coef_reg[paddr[PADDR_WIDTH-1:2]] = pwdata[COEF_WIDTH-1:0];
         if (req_valid && !req_stall)
            expected_words.push_back(filter_sample(req_sample_in));
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: output word %0d with none expected", $time, rsp_sample_out);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (rsp_sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d, got %0d",
                           $time, want, rsp_sample_out);
                  mismatches++;
               end
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// File: dv/iir_direct_form2_filter_tb.sv
`timescale 1ns / 1ps

module iir_direct_form2_filter_tb;
   import iirdf2_pkg::*;

   localparam int HISTORY_DEPTH   = 3;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int CLOCK_PERIOD    = 10;
   localparam int SETTLE_CYCLES   = 16;
   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int WORDS_PER_PHASE = 115;

   localparam int STALL_NONE    = 0;
   localparam int STALL_SCATTER = 1;
   localparam int STALL_BURSTY  = 2;

   localparam int COEFS_STABLE    = 0;
   localparam int COEFS_FULL      = 1;
   localparam int COEFS_LOW_ORDER = 2;
   localparam int COEFS_FIR       = 3;
   localparam int COEFS_EXTREME   = 4;

   localparam logic [REG_WIDTH-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = ~SAMPLE_MIN;
   localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = ~COEF_MIN;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [PADDR_WIDTH-1:0]         paddr = '0;
   logic [PDATA_WIDTH-1:0]         pwdata = '0;
   logic [PDATA_WIDTH-1:0]         prdata;
   logic                           pready;

   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int idle_cycles = 0;
   int words_sent = 0;
   int coef_sets = 0;
   int mismatches;
   int words_pending;
   int words_checked;
   int aux_clamps;
   int out_clamps;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   iir_direct_form2_filter #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   iir_direct_form2_filter_checker #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatches     (mismatches),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .aux_clamps     (aux_clamps),
      .out_clamps     (out_clamps)
   );

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         case (stall_mode)
            STALL_SCATTER: rsp_stall = ($urandom_range(0, 9) < 3);
            STALL_BURSTY: begin
               rsp_stall  = 1'($urandom_range(0, 1));
               stall_left = $urandom_range(0, 24);
            end
            default: rsp_stall = 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int signed_in(int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2: return SAMPLE_WIDTH'(signed_in(256));
         default: return SAMPLE_WIDTH'($urandom());
      endcase
   endfunction

   // setup + access phase; upper data bits carry junk the block must ignore
   task automatic reg_write(input logic [REG_WIDTH-1:0] index,
                            input logic signed [COEF_WIDTH-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = $urandom();
      pwdata[COEF_WIDTH-1:0] = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] x);
      req_valid     = 1'b1;
      req_sample_in = x;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic pause(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_coefs(input int style);
      logic signed [COEF_WIDTH-1:0] value;
      int order;
      int tap;
      order = $urandom_range(1, 2);
      for (int i = 0; i < NUM_REGS; i++) begin
         // tap number 0..3 for b, 1..3 for a
         tap = (i >= REG_A1) ? i - REG_A1 + 1 : i;
         case (style)
            // sum of |a| stays below one, so w does not run away
            COEFS_STABLE:    value = (i < REG_A1) ? COEF_WIDTH'(signed_in(32768)) :
                                     COEF_WIDTH'(signed_in(16384 >> tap));
            COEFS_LOW_ORDER: value = (tap > order) ? '0 :
                                     (i < REG_A1) ? COEF_WIDTH'(signed_in(32768)) :
                                     COEF_WIDTH'(signed_in(8192));
            COEFS_FIR:       value = (i < REG_A1) ? COEF_WIDTH'($urandom()) : '0;
            COEFS_EXTREME: begin
               case ($urandom_range(0, 2))
                  0: value = COEF_MIN;
                  1: value = COEF_MAX;
                  default: value = '0;
               endcase
            end
            COEFS_FULL:      value = COEF_WIDTH'($urandom());
            default:         value = '0;
         endcase
         reg_write(REG_WIDTH'(i), value);
      end
      if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, COEF_WIDTH'($urandom()));
      coef_sets++;
   endtask

   initial begin : stimulus
      logic signed [SAMPLE_WIDTH-1:0] passthru [7];
      int sent;
      int burst;
      passthru = '{SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA};

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // reset coefficients: straight pass-through, back to back
      foreach (passthru[i]) send_word(passthru[i]);

      // b0 = 0.5 puts odd samples on a rounding tie
      wait_drained();
      stall_mode = STALL_SCATTER;
      reg_write(REG_B0, 18'sd8192);
      send_word(16'sd1);
      send_word(-16'sd1);
      send_word(16'sd3);
      send_word(-16'sd3);

      // everything at the top of the range: w and y pin high
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) reg_write(REG_WIDTH'(i), COEF_MAX);
      reg_write(REG_UNUSED, '0);
      repeat (3) send_word(SAMPLE_MAX);
      repeat (2) send_word(SAMPLE_MIN);

      // most negative coefficients: history flips sign and clamps both ways
      wait_drained();
      stall_mode = STALL_BURSTY;
      for (int i = 0; i < NUM_REGS; i++) reg_write(REG_WIDTH'(i), COEF_MIN);
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         if (phase <= COEFS_EXTREME)
            load_coefs(phase);
         else
            load_coefs(($urandom_range(0, 9) < 4) ? COEFS_STABLE : $urandom_range(0, 4));
         stall_mode = phase % 3;
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int j = 0; j < burst && sent < WORDS_PER_PHASE; j++) begin
               send_word(pick_sample());
               sent++;
            end
            if ($urandom_range(0, 29) == 0)
               wait_drained();
            else if ($urandom_range(0, 2) != 0)
               pause($urandom_range(1, 15));
         end
      end

      wait_drained();
      $display("%0d samples sent, %0d output words checked, %0d random coefficient sets",
               words_sent, words_checked, coef_sets);
      $display("w saturated on %0d samples, output saturated on %0d", aux_clamps, out_clamps);
      if (mismatches == 0 && words_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
